// File: rtl/core/pnrg_pkg.sv
// ----------------------------------------------------------------------------
// pnrg_pkg
// Shared types, constants and the sequencer program of the noise generator.
// ----------------------------------------------------------------------------
package pnrg_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned PC_W     = 4;
    localparam int unsigned CNT_W    = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NOISE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANGED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 8'd1;

    // hash constants
    localparam logic [DATA_W-1:0] MIX_A    = 32'h68E3_1DA4;
    localparam logic [DATA_W-1:0] MIX_B    = 32'hB529_7A4D;
    localparam logic [DATA_W-1:0] MIX_C    = 32'h1B56_C4E9;
    localparam logic [DATA_W-1:0] STRIDE_Y = 32'd198491317;
    localparam logic [DATA_W-1:0] STRIDE_Z = 32'd6542989;

    // program entry points
    localparam logic [PC_W-1:0] PC_COORD = 4'd0;
    localparam logic [PC_W-1:0] PC_POS   = 4'd4;
    localparam logic [PC_W-1:0] PC_HASH  = 4'd5;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd13;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_Y,
        OP_ACC_X,
        OP_MUL_Z,
        OP_ADD_PROD,
        OP_LOAD_POS,
        OP_MUL_A,
        OP_MIX1,
        OP_MIX2,
        OP_MUL_C,
        OP_MIX3,
        OP_RANGE_SETUP,
        OP_DIV_STEP,
        OP_RANGE_ADD,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_NOT_RANGED,
        JMP_RANGE_BAD,
        JMP_LOOP
    } t_jmp;

    typedef struct packed {
        t_op             op;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_dp_ctrl;

    typedef struct packed {
        logic range_bad;
        logic loop_more;
        logic is_ranged;
    } t_dp_stat;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_EMIT, jmp: JMP_NONE, target: PC_EMIT};
        unique case (pc)
            4'd0:  w = '{op: OP_MUL_Y,       jmp: JMP_NONE,       target: PC_EMIT};
            4'd1:  w = '{op: OP_ACC_X,       jmp: JMP_NONE,       target: PC_EMIT};
            4'd2:  w = '{op: OP_MUL_Z,       jmp: JMP_NONE,       target: PC_EMIT};
            4'd3:  w = '{op: OP_ADD_PROD,    jmp: JMP_ALWAYS,     target: PC_HASH};
            4'd4:  w = '{op: OP_LOAD_POS,    jmp: JMP_NONE,       target: PC_EMIT};
            4'd5:  w = '{op: OP_MUL_A,       jmp: JMP_NONE,       target: PC_EMIT};
            4'd6:  w = '{op: OP_MIX1,        jmp: JMP_NONE,       target: PC_EMIT};
            4'd7:  w = '{op: OP_MIX2,        jmp: JMP_NONE,       target: PC_EMIT};
            4'd8:  w = '{op: OP_MUL_C,       jmp: JMP_NONE,       target: PC_EMIT};
            4'd9:  w = '{op: OP_MIX3,        jmp: JMP_NOT_RANGED, target: PC_EMIT};
            4'd10: w = '{op: OP_RANGE_SETUP, jmp: JMP_RANGE_BAD,  target: PC_EMIT};
            4'd11: w = '{op: OP_DIV_STEP,    jmp: JMP_LOOP,       target: PC_DIV};
            4'd12: w = '{op: OP_RANGE_ADD,   jmp: JMP_NONE,       target: PC_EMIT};
            default: w = '{op: OP_EMIT,      jmp: JMP_NONE,       target: PC_EMIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/pnrg_ifs.sv
// ----------------------------------------------------------------------------
// pnrg channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pnrg_cmd_if import pnrg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] range_min;
    logic signed [DATA_W-1:0] range_max;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, range_min, range_max,
                    input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, range_min, range_max,
                    output ready);
endinterface

interface pnrg_res_if import pnrg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [DATA_W-1:0]        value;
    logic signed [DATA_W-1:0] ranged;
    logic                     range_error;

    modport source (output valid, value, ranged, range_error, input ready);
    modport sink   (input valid, value, ranged, range_error, output ready);
endinterface

interface pnrg_cfg_if import pnrg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/pnrg_datapath.sv
// ----------------------------------------------------------------------------
// pnrg_datapath
// Shared multiplier, mixing logic and bit-serial range reduction, driven one
// operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module pnrg_datapath import pnrg_pkg::*; (
    input  logic                     i_clk,
    input  t_dp_ctrl                 i_ctrl,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [DATA_W-1:0]        i_pos_x,
    input  logic [DATA_W-1:0]        i_pos_y,
    input  logic [DATA_W-1:0]        i_pos_z,
    input  logic [DATA_W-1:0]        i_range_min,
    input  logic [DATA_W-1:0]        i_range_max,
    input  logic [DATA_W-1:0]        i_seed,
    input  logic [DATA_W-1:0]        i_position,
    output t_dp_stat                 o_stat,
    output logic [DATA_W-1:0]        o_value,
    output logic [DATA_W-1:0]        o_ranged,
    output logic                     o_range_error
);

    logic [CMD_W-1:0]  r_cmd;
    logic [DATA_W-1:0] r_x, r_y, r_z, r_lo, r_hi;
    logic [DATA_W-1:0] r_acc, r_prod, r_val, r_div, r_rem, r_ranged;
    logic [DATA_W:0]   r_span;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_err;

    logic [DATA_W-1:0] mul_a, mul_b, mul_p;
    logic [DATA_W-1:0] mix_t, mix_u, mix_w;
    logic [DATA_W:0]   trial, span;
    logic              range_bad;

    always_comb begin
        unique case (i_ctrl.op)
            OP_MUL_Y: begin mul_a = r_y;   mul_b = STRIDE_Y; end
            OP_MUL_Z: begin mul_a = r_z;   mul_b = STRIDE_Z; end
            OP_MUL_A: begin mul_a = r_acc; mul_b = MIX_A;    end
            default:  begin mul_a = r_acc; mul_b = MIX_C;    end
        endcase
    end

    assign mul_p = mul_a * mul_b;       // low 32 bits of the product

    assign mix_t = r_prod + i_seed;
    assign mix_u = r_acc + MIX_B;
    assign mix_w = r_prod ^ (r_prod >> 8);

    assign range_bad = $signed(r_hi) < $signed(r_lo);
    assign span      = {r_hi[DATA_W-1], r_hi} - {r_lo[DATA_W-1], r_lo} + (DATA_W+1)'(1);
    // remainder stays below span, so shifted value fits in 33 bits
    assign trial     = {r_rem, r_div[DATA_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= i_cmd;
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_z      <= i_pos_z;
            r_lo     <= i_range_min;
            r_hi     <= i_range_max;
            r_ranged <= '0;
            r_err    <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                OP_MUL_Y, OP_MUL_Z, OP_MUL_A, OP_MUL_C: r_prod <= mul_p;
                OP_ACC_X:    r_acc <= r_x + r_prod;
                OP_ADD_PROD: r_acc <= r_acc + r_prod;
                OP_LOAD_POS: r_acc <= i_position;
                OP_MIX1:     r_acc <= mix_t ^ (mix_t >> 8);
                OP_MIX2:     r_acc <= mix_u ^ (mix_u << 8);
                OP_MIX3: begin
                    r_val <= mix_w;
                    r_div <= mix_w;
                end
                OP_RANGE_SETUP: begin
                    r_span <= span;
                    r_rem  <= '0;
                    r_cnt  <= CNT_W'(DATA_W - 1);
                    r_err  <= range_bad;
                    if (range_bad) begin
                        r_ranged <= r_lo;
                    end
                end
                OP_DIV_STEP: begin
                    if (trial >= r_span) begin
                        r_rem <= DATA_W'(trial - r_span);
                    end else begin
                        r_rem <= trial[DATA_W-1:0];
                    end
                    r_div <= r_div << 1;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                OP_RANGE_ADD: r_ranged <= r_lo + r_rem;
                default: ;
            endcase
        end
    end

    assign o_stat.range_bad = range_bad;
    assign o_stat.loop_more = (r_cnt != '0);
    assign o_stat.is_ranged = (r_cmd == CMD_RANGED);
    assign o_value          = r_val;
    assign o_ranged         = r_ranged;
    assign o_range_error    = r_err;

endmodule

// File: rtl/core/positional_noise_random_generator_core.sv
// ----------------------------------------------------------------------------
// positional_noise_random_generator_core
// Counter-based noise hash: coordinate noise, raw draws and ranged draws
// computed by a small microprogram over a shared multiplier datapath.
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------
//   i_cmd    | in  | cmd, pos_x, pos_y, pos_z, range_min, range_max
//   o_res    | out | value, ranged, range_error
//   i_cfg    | in  | index (0 seed, 1 start_position), data
//
// A ranged draw runs the one-bit-per-cycle modulo loop, which is skipped when
// the range is inverted. Command 3 is dropped on accept.
// i_cmd is ready only while the sequencer is idle; the result register lets
// the next command start while a result waits. The sequencer holds on its
// last step while the result register is full. Reset clears seed and
// position to zero. Config writes are always accepted.
// ----------------------------------------------------------------------------
module positional_noise_random_generator_core import pnrg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pnrg_cmd_if.sink   i_cmd,
    pnrg_res_if.source o_res,
    pnrg_cfg_if.sink   i_cfg
);

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    t_seq_state        r_state;
    logic [PC_W-1:0]   r_pc;
    logic [DATA_W-1:0] r_seed, r_position;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value, r_out_ranged;
    logic              r_out_error;

    t_uword            uw;
    t_dp_ctrl          dp_ctrl;
    t_dp_stat          dp_stat;
    logic              cmd_fire, jump, out_free;
    logic [DATA_W-1:0] dp_value, dp_ranged;
    logic              dp_error;

    assign uw       = ucode(r_pc);
    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        unique case (uw.jmp)
            JMP_ALWAYS:     jump = 1'b1;
            JMP_NOT_RANGED: jump = !dp_stat.is_ranged;
            JMP_RANGE_BAD:  jump = dp_stat.range_bad;
            JMP_LOOP:       jump = dp_stat.loop_more;
            default:        jump = 1'b0;
        endcase
    end

    assign dp_ctrl.load = cmd_fire;
    assign dp_ctrl.op   = (r_state == SEQ_RUN) ? uw.op : OP_NONE;

    pnrg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_ctrl        (dp_ctrl),
        .i_cmd         (i_cmd.cmd),
        .i_pos_x       (i_cmd.pos_x),
        .i_pos_y       (i_cmd.pos_y),
        .i_pos_z       (i_cmd.pos_z),
        .i_range_min   (i_cmd.range_min),
        .i_range_max   (i_cmd.range_max),
        .i_seed        (r_seed),
        .i_position    (r_position),
        .o_stat        (dp_stat),
        .o_value       (dp_value),
        .o_ranged      (dp_ranged),
        .o_range_error (dp_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_pc        <= PC_COORD;
            r_seed      <= '0;
            r_position  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_SEED) begin
                    r_seed <= i_cfg.data;
                end else if (i_cfg.index == CFG_START) begin
                    r_position <= i_cfg.data;
                end
            end
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                SEQ_IDLE: begin
                    if (cmd_fire) begin
                        if (i_cmd.cmd == CMD_NOISE) begin
                            r_state <= SEQ_RUN;
                            r_pc    <= PC_COORD;
                        end else if (i_cmd.cmd == CMD_DRAW || i_cmd.cmd == CMD_RANGED) begin
                            r_state <= SEQ_RUN;
                            r_pc    <= PC_POS;
                        end
                    end
                end
                SEQ_RUN: begin
                    if (uw.op == OP_EMIT) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_value  <= dp_value;
                            r_out_ranged <= dp_ranged;
                            r_out_error  <= dp_error;
                            r_state      <= SEQ_IDLE;
                        end
                    end else begin
                        r_pc <= jump ? uw.target : r_pc + PC_W'(1);
                        if (uw.op == OP_LOAD_POS) begin
                            r_position <= r_position + DATA_W'(1);
                        end
                    end
                end
                default: r_state <= SEQ_IDLE;
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == SEQ_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_out_valid;
    assign o_res.value       = r_out_value;
    assign o_res.ranged      = r_out_ranged;
    assign o_res.range_error = r_out_error;

endmodule

// File: tb/tb_positional_noise_random_generator_core.sv
// ----------------------------------------------------------------------------
// tb_positional_noise_random_generator_core
// Self-checking bench for the noise hash generator. A scoreboard class keeps
// its own seed and position, predicts every draw from the accepted commands,
// and checks each result transaction in order. Directed corner cases come
// first, then random phases under several register settings, with bursty
// command traffic, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_positional_noise_random_generator_core;
    import pnrg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_UNITS = 5_000_000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } noise_req_t;

    typedef struct {
        logic [DATA_W-1:0]        value;
        logic signed [DATA_W-1:0] ranged;
        logic                     err;
    } noise_draw_t;

    class noise_scoreboard;
        logic [DATA_W-1:0] seed;
        logic [DATA_W-1:0] position;
        noise_draw_t       expected_draws[$];
        int                mismatches;

        function new();
            seed = '0;
            position = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            $display("mismatch %s: got %08h want %08h", what, got, want);
            mismatches++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == CFG_SEED) begin
                seed = data;
            end else if (idx == CFG_START) begin
                position = data;
            end
        endfunction

        function logic [DATA_W-1:0] mix_position(logic [DATA_W-1:0] p);
            logic [DATA_W-1:0] h;
            h = p * MIX_A;
            h = h + seed;
            h = h ^ (h >> 8);
            h = h + MIX_B;
            h = h ^ (h << 8);
            h = h * MIX_C;
            h = h ^ (h >> 8);
            return h;
        endfunction

        function void note_request(noise_req_t r);
            noise_draw_t d;
            longint      span;
            longint      off;
            d.value = '0;
            d.ranged = '0;
            d.err = 1'b0;
            if (r.cmd == CMD_UNUSED)
                return;
            if (r.cmd == CMD_NOISE) begin
                d.value = mix_position(r.x + STRIDE_Y * r.y + STRIDE_Z * r.z);
            end else begin
                d.value = mix_position(position);
                position = position + 1;
                if (r.cmd == CMD_RANGED) begin
                    if (r.hi < r.lo) begin
                        d.err = 1'b1;
                        d.ranged = r.lo;
                    end else begin
                        span = longint'(r.hi) - longint'(r.lo) + 1;
                        off = longint'({32'b0, d.value}) % span;
                        d.ranged = r.lo + off[DATA_W-1:0];
                    end
                end
            end
            expected_draws.push_back(d);
        endfunction

        task check_result(logic [DATA_W-1:0] value, logic [DATA_W-1:0] ranged, logic err);
            noise_draw_t d;
            if (expected_draws.size() == 0) begin
                report("unexpected result", value, '0);
                return;
            end
            d = expected_draws.pop_front();
            if (value !== d.value)
                report("value", value, d.value);
            if (ranged !== d.ranged)
                report("ranged", ranged, d.ranged);
            if (err !== d.err)
                report("range_error", {31'b0, err}, {31'b0, d.err});
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   hold_req;

    pnrg_cmd_if cmd_ch ();
    pnrg_res_if res_ch ();
    pnrg_cfg_if cfg_ch ();

    noise_scoreboard sb = new();

    positional_noise_random_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("Regression FAIL");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.value, res_ch.ranged, res_ch.range_error);
    end

    // receiver: stall pattern chosen per window, plus the long hold-off
    initial begin : rx_proc
        int mode;
        int cyc;
        mode = 0;
        cyc = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: res_ch.ready = 1'b1;
                1: res_ch.ready = ($urandom_range(0, 9) < 7);
                2: res_ch.ready = (cyc % 5 != 0);
                default: res_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
            cyc++;
        end
    end

    function noise_req_t mk_req(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] x,
                                logic signed [DATA_W-1:0] y, logic signed [DATA_W-1:0] z,
                                logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
        noise_req_t r;
        r.cmd = cmd;
        r.x = x;
        r.y = y;
        r.z = z;
        r.lo = lo;
        r.hi = hi;
        return r;
    endfunction

    function logic signed [DATA_W-1:0] pick_edge();
        case ($urandom_range(0, 3))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            default: return -1;
        endcase
    endfunction

    function noise_req_t rand_req();
        noise_req_t               r;
        int                       sel;
        logic signed [DATA_W-1:0] t;
        longint                   span;
        sel = $urandom_range(0, 99);
        r.cmd = (sel < 35) ? CMD_NOISE : (sel < 60) ? CMD_DRAW :
                (sel < 95) ? CMD_RANGED : CMD_UNUSED;
        r.x = $urandom;
        r.y = $urandom;
        r.z = $urandom;
        case ($urandom_range(0, 9))
            6: begin
                r.y = '0;
                r.z = '0;
            end
            7: r.z = '0;
            8: begin
                r.x = pick_edge();
                r.y = pick_edge();
                r.z = pick_edge();
            end
            default: ;
        endcase
        r.lo = $urandom;
        r.hi = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                // inverted bounds
                if (r.hi > r.lo) begin
                    t = r.hi;
                    r.hi = r.lo;
                    r.lo = t;
                end else if (r.hi == r.lo) begin
                    if (r.lo != S_MIN) r.hi = r.lo - 1;
                    else r.lo = r.lo + 1;
                end
            end
            1: begin
                r.lo = S_MIN;
                r.hi = S_MAX;
            end
            2: r.hi = r.lo;
            3, 4, 5: begin
                span = $urandom_range(0, 1000);
                if (longint'(r.lo) > longint'(S_MAX) - span)
                    r.lo = S_MAX - span[DATA_W-1:0];
                r.hi = r.lo + span[DATA_W-1:0];
            end
            default: begin
                if (r.hi < r.lo) begin
                    t = r.hi;
                    r.hi = r.lo;
                    r.lo = t;
                end
            end
        endcase
        return r;
    endfunction

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // valid stays high across back-to-back calls
    task send_cmd(noise_req_t r);
        @(negedge i_clk);
        cmd_ch.valid = 1'b1;
        cmd_ch.cmd = r.cmd;
        cmd_ch.pos_x = r.x;
        cmd_ch.pos_y = r.y;
        cmd_ch.pos_z = r.z;
        cmd_ch.range_min = r.lo;
        cmd_ch.range_max = r.hi;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_request(r);
    endtask

    task idle_cmd(int n);
        if (n > 0) begin
            @(negedge i_clk);
            cmd_ch.valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // dropped commands leave no result, so allow for the longest sequence
    task wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task run_phase(int p);
        noise_req_t r;
        int         sent;
        int         burst;
        bit         gapless;
        sent = 0;
        gapless = (p == 1) || (p == 4);
        while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                r = rand_req();
                send_cmd(r);
                if (r.cmd != CMD_UNUSED)
                    sent++;
            end
            if (!gapless && $urandom_range(0, 3) != 0)
                idle_cmd($urandom_range(1, 8));
        end
        idle_cmd(1);
    endtask

    initial begin : stim
        int p;
        i_rst_n = 1'b0;
        hold_req = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_NOISE;
        cmd_ch.pos_x = '0;
        cmd_ch.pos_y = '0;
        cmd_ch.pos_z = '0;
        cmd_ch.range_min = '0;
        cmd_ch.range_max = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SEED;
        cfg_ch.data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: low register extremes
        write_reg(CFG_SEED, 32'h0000_0000);
        write_reg(CFG_START, 32'h0000_0000);
        send_cmd(mk_req(CMD_NOISE, 0, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_NOISE, S_MIN, S_MIN, S_MIN, 0, 0));
        send_cmd(mk_req(CMD_NOISE, S_MAX, S_MAX, S_MAX, 0, 0));
        send_cmd(mk_req(CMD_NOISE, -1, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_NOISE, 12345, -7, 0, 0, 0));
        send_cmd(mk_req(CMD_DRAW, 0, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_DRAW, -1, -1, -1, -1, -1));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, S_MIN, S_MAX));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, 5, -5));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, 42, 42));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, 0, 1));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, -100, 100));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, 0, S_MAX));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, S_MAX, S_MIN));
        send_cmd(mk_req(CMD_UNUSED, S_MAX, S_MIN, -1, S_MIN, S_MAX));
        send_cmd(mk_req(CMD_DRAW, 0, 0, 0, 0, 0));
        idle_cmd(1);
        wait_drained();

        // directed: high register extremes, position wraps
        write_reg(CFG_SEED, 32'hFFFF_FFFF);
        write_reg(CFG_START, 32'hFFFF_FFFE);
        send_cmd(mk_req(CMD_DRAW, 0, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_DRAW, 0, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, S_MIN, -1));
        send_cmd(mk_req(CMD_DRAW, 0, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_NOISE, S_MAX, S_MIN, S_MAX, 0, 0));
        send_cmd(mk_req(CMD_UNUSED, 0, 0, 0, 0, 0));
        send_cmd(mk_req(CMD_RANGED, 0, 0, 0, S_MIN, S_MAX));
        idle_cmd(1);

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    write_reg(CFG_SEED, 32'h0000_0000);
                    write_reg(CFG_START, $urandom);
                end
                1: begin
                    write_reg(CFG_SEED, 32'hFFFF_FFFF);
                    write_reg(CFG_START, 32'hFFFF_FF80);
                    hold_req = 1'b1;
                end
                2: begin
                    write_reg(CFG_SEED, $urandom);
                    write_reg(CFG_START, 32'h0000_0000);
                end
                3: begin
                    write_reg(CFG_SEED, $urandom);
                    write_reg(CFG_START, 32'hFFFF_FFFF);
                end
                4: begin
                    write_reg(CFG_SEED, $urandom);
                    write_reg(CFG_START, $urandom);
                end
                default: begin
                    write_reg(CFG_SEED, 32'h0000_0000);
                    write_reg(CFG_START, 32'h0000_0000);
                end
            endcase
            run_phase(p);
        end

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
